### rtl/fsn_pkg.sv
package fsn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    // Accumulator widths are sized for the largest supported octave count.
    localparam int OCT_LIMIT = 16;

    localparam int CNT_W   = 4;
    localparam int REG_W   = 24;
    localparam int COORD_W = 32;
    localparam int OUT_W   = 18;
    localparam int IDX_W   = 3;

    localparam int NOISE_W = 24;
    localparam int WP_W    = 48;
    localparam int SUM_W   = WP_W + $clog2(OCT_LIMIT);
    localparam int TOT_W   = REG_W + $clog2(OCT_LIMIT);
    localparam int MAG_W   = SUM_W - 1;

    localparam int OCT_STAGES = 13;
    localparam int DIV_STAGES = OUT_W + 1;

    localparam int FX_ONE  = 65536;
    localparam int FX_HALF = 32768;
    localparam logic signed [15:0] SKEW_F     = 16'sd23988;
    localparam logic signed [14:0] SKEW_G     = 15'sd13849;
    localparam logic signed [22:0] NOISE_GAIN = 23'sd2964236;

    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(131071);
    localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(-131072);

    localparam logic [CNT_W-1:0] RST_OCTAVE_COUNT   = CNT_W'(1);
    localparam logic [REG_W-1:0] RST_BASE_FREQUENCY = REG_W'(65536);
    localparam logic [REG_W-1:0] RST_BASE_AMPLITUDE = REG_W'(65536);
    localparam logic [REG_W-1:0] RST_LACUNARITY     = REG_W'(131072);
    localparam logic [REG_W-1:0] RST_PERSISTENCE    = REG_W'(32768);

    typedef enum logic [IDX_W-1:0] {
        REG_OCTAVE_COUNT   = 3'd0,
        REG_BASE_FREQUENCY = 3'd1,
        REG_BASE_AMPLITUDE = 3'd2,
        REG_LACUNARITY     = 3'd3,
        REG_PERSISTENCE    = 3'd4
    } fsn_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0] octave_count;
        logic [REG_W-1:0] lacunarity;
        logic [REG_W-1:0] persistence;
    } fsn_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [REG_W-1:0]          freq;
        logic [REG_W-1:0]          amp;
        logic signed [SUM_W-1:0]   sum;
        logic [TOT_W-1:0]          total;
    } fsn_oct_bus_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [TOT_W-1:0] den;
        logic [OUT_W-1:0] quo;
        logic             neg;
        logic             ovf;
        logic             zero;
    } fsn_div_bus_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Q8.16 scale with saturation to the register range.
    function automatic logic [REG_W-1:0] scale_sat(input logic [REG_W-1:0] a,
                                                   input logic [REG_W-1:0] m);
        logic [2*REG_W-1:0] p;
        p = a * m;
        if (|p[2*REG_W-1:REG_W+16]) begin
            return {REG_W{1'b1}};
        end
        return p[REG_W+15:16];
    endfunction

endpackage

### rtl/fsn_octave_cell.sv
module fsn_octave_cell #(
    parameter int K = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  fsn_pkg::fsn_cfg_t    cfg,
    input  logic                 in_vld,
    input  fsn_pkg::fsn_oct_bus_t in_bus,
    output logic                 out_vld,
    output fsn_pkg::fsn_oct_bus_t out_bus
);
    import fsn_pkg::*;

    localparam int P_W   = 36;
    localparam int S_W   = 37;
    localparam int C_W   = 22;
    localparam int X_W   = 40;
    localparam int XS_W  = 17;
    localparam int G_W   = 19;
    localparam int CON_W = 32;
    localparam int ACC_W = 34;
    localparam int NCOR  = 3;

    localparam logic signed [X_W-1:0] ONE_X    = X_W'(FX_ONE);
    localparam logic signed [X_W-1:0] G_X      = X_W'(13849);
    localparam logic signed [X_W-1:0] NEAR_MAX = X_W'(FX_ONE - 1);

    logic                 vld_reg [OCT_STAGES];
    fsn_oct_bus_t         bus_reg [OCT_STAGES-1];
    fsn_oct_bus_t         out_next;

    // stage 0: coordinate scale
    logic signed [COORD_W+REG_W:0] mx_full, my_full;
    logic signed [P_W-1:0]         px_reg, py_reg;
    fsn_oct_bus_t                  bus0_next;

    // stage 1: skew
    logic signed [P_W:0]           psum;
    logic signed [P_W+16:0]        sk_prod;
    logic signed [S_W-1:0]         s_reg;
    logic signed [P_W-1:0]         px1_reg, py1_reg;

    // stage 2: cell indices
    logic signed [S_W:0]           ax, ay;
    logic signed [C_W-1:0]         ci_reg, cj_reg;
    logic signed [P_W-1:0]         px2_reg, py2_reg;

    // stage 3: first corner offset and row hashes
    logic signed [C_W:0]           csum;
    logic signed [C_W+15:0]        unskew;
    logic signed [X_W-1:0]         x0_next, y0_next, x0_reg, y0_reg;
    logic [7:0]                    ci8_reg, pj0_reg, pj1_reg;

    // stage 4: corner offsets and gradient hashes
    logic                          oi;
    logic signed [X_W-1:0]         xc_next [NCOR];
    logic signed [X_W-1:0]         yc_next [NCOR];
    logic [5:0]                    hc_next [NCOR];
    logic signed [X_W-1:0]         xc_reg  [NCOR];
    logic signed [X_W-1:0]         yc_reg  [NCOR];
    logic [5:0]                    hc_reg  [NCOR];

    // stages 5 to 8: falloff and gradient per corner
    logic [15:0]                   t_next  [NCOR];
    logic signed [G_W-1:0]         gr_next [NCOR];
    logic [15:0]                   t_reg   [NCOR];
    logic signed [G_W-1:0]         gr5_reg [NCOR];
    logic [15:0]                   t2_reg  [NCOR];
    logic signed [G_W-1:0]         gr6_reg [NCOR];
    logic [15:0]                   t4_reg  [NCOR];
    logic signed [G_W-1:0]         gr7_reg [NCOR];
    logic signed [CON_W-1:0]       con_reg [NCOR];

    // stages 9 to 11: gain and weighting
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W+22:0]      gprod;
    logic signed [NOISE_W-1:0]     noise_reg;
    logic signed [WP_W:0]          wprod_full;
    logic signed [WP_W-1:0]        wprod_reg;
    logic [REG_W-1:0]              amp_next_reg;
    logic                          active;

    // stage 0
    assign mx_full = in_bus.coord_x * $signed({1'b0, in_bus.freq});
    assign my_full = in_bus.coord_y * $signed({1'b0, in_bus.freq});

    always_comb begin
        bus0_next = in_bus;
        bus0_next.freq = scale_sat(in_bus.freq, cfg.lacunarity);
    end

    // stage 1
    assign psum    = (P_W+1)'(px_reg) + (P_W+1)'(py_reg);
    assign sk_prod = psum * SKEW_F;

    // stage 2
    assign ax = (S_W+1)'(px1_reg) + (S_W+1)'(s_reg);
    assign ay = (S_W+1)'(py1_reg) + (S_W+1)'(s_reg);

    // stage 3
    assign csum    = (C_W+1)'(ci_reg) + (C_W+1)'(cj_reg);
    assign unskew  = csum * SKEW_G;
    assign x0_next = X_W'(px2_reg) - (X_W'(ci_reg) <<< 16) + X_W'(unskew);
    assign y0_next = X_W'(py2_reg) - (X_W'(cj_reg) <<< 16) + X_W'(unskew);

    // stage 4: the middle corner steps along x when x0 > y0, else along y.
    always_comb begin
        oi = x0_reg > y0_reg;
        xc_next[0] = x0_reg;
        yc_next[0] = y0_reg;
        xc_next[1] = x0_reg - (oi ? ONE_X : '0) + G_X;
        yc_next[1] = y0_reg - (oi ? '0 : ONE_X) + G_X;
        xc_next[2] = x0_reg - ONE_X + (G_X <<< 1);
        yc_next[2] = y0_reg - ONE_X + (G_X <<< 1);
        hc_next[0] = PERM_ROM[8'(ci8_reg + pj0_reg)][5:0];
        hc_next[1] = PERM_ROM[8'(ci8_reg + {7'd0, oi} + (oi ? pj0_reg : pj1_reg))][5:0];
        hc_next[2] = PERM_ROM[8'(ci8_reg + 8'd1 + pj1_reg)][5:0];
    end

    // stage 5: a corner farther than one unit on either axis has no weight.
    generate
        for (genvar c = 0; c < NCOR; c++) begin : g_corner
            logic                    near;
            logic signed [XS_W-1:0]  xs, ys, u, v;
            logic signed [2*XS_W-1:0] xx, yy;
            logic [18:0]             sq;
            logic signed [G_W-1:0]   ua, vb, ga, gb;

            assign near = (xc_reg[c] <= NEAR_MAX) && (xc_reg[c] >= -NEAR_MAX) &&
                          (yc_reg[c] <= NEAR_MAX) && (yc_reg[c] >= -NEAR_MAX);
            assign xs   = xc_reg[c][XS_W-1:0];
            assign ys   = yc_reg[c][XS_W-1:0];
            assign xx   = xs * xs;
            assign yy   = ys * ys;
            assign sq   = 19'(xx[2*XS_W-1:16]) + 19'(yy[2*XS_W-1:16]);
            assign t_next[c] = (near && sq <= 19'(FX_HALF)) ? 16'(19'(FX_HALF) - sq) : '0;

            assign u  = (hc_reg[c][5:2] == 4'd0) ? xs : ys;
            assign v  = (hc_reg[c][5:2] == 4'd0) ? ys : xs;
            assign ua = G_W'(u);
            assign vb = G_W'(v) <<< 1;
            assign ga = hc_reg[c][0] ? -ua : ua;
            assign gb = hc_reg[c][1] ? -vb : vb;
            assign gr_next[c] = ga + gb;
        end
    endgenerate

    // stages 10 and 11
    assign gprod      = acc_reg * NOISE_GAIN;
    assign wprod_full = $signed({1'b0, bus_reg[10].amp}) * noise_reg;
    assign active     = cfg.octave_count > CNT_W'(K);

    always_comb begin
        out_next = bus_reg[11];
        out_next.amp = amp_next_reg;
        if (active) begin
            out_next.sum   = bus_reg[11].sum + SUM_W'(wprod_reg);
            out_next.total = bus_reg[11].total + TOT_W'(bus_reg[11].amp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < OCT_STAGES; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < OCT_STAGES; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bus_reg[0] <= bus0_next;
            for (int s = 1; s < OCT_STAGES - 1; s++) begin
                bus_reg[s] <= bus_reg[s-1];
            end
            px_reg  <= mx_full[COORD_W+REG_W:21];
            py_reg  <= my_full[COORD_W+REG_W:21];
            s_reg   <= sk_prod[P_W+16:16];
            px1_reg <= px_reg;
            py1_reg <= py_reg;
            ci_reg  <= ax[S_W:16];
            cj_reg  <= ay[S_W:16];
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            ci8_reg <= ci_reg[7:0];
            pj0_reg <= PERM_ROM[cj_reg[7:0]];
            pj1_reg <= PERM_ROM[8'(cj_reg[7:0] + 8'd1)];
            for (int c = 0; c < NCOR; c++) begin
                xc_reg[c]  <= xc_next[c];
                yc_reg[c]  <= yc_next[c];
                hc_reg[c]  <= hc_next[c];
                t_reg[c]   <= t_next[c];
                gr5_reg[c] <= gr_next[c];
                t2_reg[c]  <= 16'((32'(t_reg[c]) * 32'(t_reg[c])) >> 16);
                gr6_reg[c] <= gr5_reg[c];
                t4_reg[c]  <= 16'((32'(t2_reg[c]) * 32'(t2_reg[c])) >> 16);
                gr7_reg[c] <= gr6_reg[c];
                con_reg[c] <= CON_W'($signed({1'b0, t4_reg[c]}) * gr7_reg[c]);
            end
            acc_reg      <= ACC_W'(con_reg[0]) + ACC_W'(con_reg[1]) + ACC_W'(con_reg[2]);
            noise_reg    <= gprod[NOISE_W+31:32];
            wprod_reg    <= wprod_full[WP_W-1:0];
            amp_next_reg <= scale_sat(bus_reg[10].amp, cfg.persistence);
            out_bus      <= out_next;
        end
    end

    assign out_vld = vld_reg[OCT_STAGES-1];

endmodule

### rtl/fsn_div_cell.sv
module fsn_div_cell #(
    parameter int BIT = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  fsn_pkg::fsn_div_bus_t in_bus,
    output logic                  out_vld,
    output fsn_pkg::fsn_div_bus_t out_bus
);
    import fsn_pkg::*;

    logic [MAG_W-1:0] shifted;
    fsn_div_bus_t     bus_next;
    logic             vld_reg;

    assign shifted = MAG_W'(in_bus.den) << BIT;

    // The top cell only flags a quotient too large for the output; the rest
    // each settle one quotient bit.
    generate
        if (BIT >= OUT_W) begin : g_ovf
            always_comb begin
                bus_next = in_bus;
                bus_next.ovf = in_bus.rem >= shifted;
            end
        end else begin : g_bit
            always_comb begin
                bus_next = in_bus;
                if (!in_bus.ovf && in_bus.rem >= shifted) begin
                    bus_next.rem = in_bus.rem - shifted;
                    bus_next.quo[BIT] = 1'b1;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_bus <= bus_next;
        end
    end

    assign out_vld = vld_reg;

endmodule

### rtl/fractal_simplex_noise_2d.sv
// Channel   Ports                                       Dir  Beat
// input     s_valid s_ready s_coord_x s_coord_y          in   one coordinate
// result    m_valid m_ready m_noise_value                out  one noise value
// config    cfg_valid cfg_ready cfg_index cfg_data       in   one register write
//
// One coordinate is accepted per cycle unless the pipe is frozen. The path holds
// thirteen stages per octave cell, one sign stage, nineteen divider cells and
// the output register. Reset clears all valid flags and loads register defaults.
// When a finished beat reaches the tail while the output register is held, the
// whole pipe freezes, input included, until m_ready returns; the config port is
// always ready.
module fractal_simplex_noise_2d #(
    parameter int MAX_OCTAVES = fsn_pkg::MAX_OCTAVES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [fsn_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [fsn_pkg::COORD_W-1:0] s_coord_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [fsn_pkg::OUT_W-1:0]   m_noise_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsn_pkg::IDX_W-1:0]          cfg_index,
    input  logic [fsn_pkg::REG_W-1:0]          cfg_data
);
    import fsn_pkg::*;

    logic [CNT_W-1:0] octave_count_reg;
    logic [REG_W-1:0] base_frequency_reg;
    logic [REG_W-1:0] base_amplitude_reg;
    logic [REG_W-1:0] lacunarity_reg;
    logic [REG_W-1:0] persistence_reg;
    fsn_cfg_t         cfg;

    logic             en;
    fsn_oct_bus_t     oct_bus [MAX_OCTAVES+1];
    logic             oct_vld [MAX_OCTAVES+1];
    fsn_div_bus_t     div_bus [DIV_STAGES+1];
    logic             div_vld [DIV_STAGES+1];

    fsn_div_bus_t     prep_next, prep_reg;
    logic             prep_vld_reg;
    logic signed [SUM_W-1:0] sum_abs;

    logic             tail_vld;
    fsn_div_bus_t     tail;
    logic signed [OUT_W-1:0] res_next, res_reg;
    logic             out_vld_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_count_reg   <= RST_OCTAVE_COUNT;
            base_frequency_reg <= RST_BASE_FREQUENCY;
            base_amplitude_reg <= RST_BASE_AMPLITUDE;
            lacunarity_reg     <= RST_LACUNARITY;
            persistence_reg    <= RST_PERSISTENCE;
        end else if (cfg_valid) begin
            case (fsn_reg_t'(cfg_index))
                REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[CNT_W-1:0];
                REG_BASE_FREQUENCY: base_frequency_reg <= cfg_data;
                REG_BASE_AMPLITUDE: base_amplitude_reg <= cfg_data;
                REG_LACUNARITY:     lacunarity_reg     <= cfg_data;
                REG_PERSISTENCE:    persistence_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.octave_count = octave_count_reg;
    assign cfg.lacunarity   = lacunarity_reg;
    assign cfg.persistence  = persistence_reg;

    // The whole pipe moves unless a finished beat sits at the tail while the
    // output register is still occupied and not being taken.
    assign tail_vld = div_vld[DIV_STAGES];
    assign tail     = div_bus[DIV_STAGES];
    assign en       = !(tail_vld && out_vld_reg && !m_ready);
    assign s_ready  = en;

    assign oct_vld[0]         = s_valid && s_ready;
    assign oct_bus[0].coord_x = s_coord_x;
    assign oct_bus[0].coord_y = s_coord_y;
    assign oct_bus[0].freq    = base_frequency_reg;
    assign oct_bus[0].amp     = base_amplitude_reg;
    assign oct_bus[0].sum     = '0;
    assign oct_bus[0].total   = '0;

    generate
        for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
            fsn_octave_cell #(.K(k)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .cfg     (cfg),
                .in_vld  (oct_vld[k]),
                .in_bus  (oct_bus[k]),
                .out_vld (oct_vld[k+1]),
                .out_bus (oct_bus[k+1])
            );
        end
    endgenerate

    // Split the weighted sum into sign and magnitude for the divider.
    always_comb begin
        sum_abs = oct_bus[MAX_OCTAVES].sum[SUM_W-1] ? -oct_bus[MAX_OCTAVES].sum
                                                    : oct_bus[MAX_OCTAVES].sum;
        prep_next.rem  = sum_abs[MAG_W-1:0];
        prep_next.den  = oct_bus[MAX_OCTAVES].total;
        prep_next.quo  = '0;
        prep_next.neg  = oct_bus[MAX_OCTAVES].sum[SUM_W-1];
        prep_next.ovf  = 1'b0;
        prep_next.zero = oct_bus[MAX_OCTAVES].total == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (en) begin
            prep_vld_reg <= oct_vld[MAX_OCTAVES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign div_vld[0] = prep_vld_reg;
    assign div_bus[0] = prep_reg;

    generate
        for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
            fsn_div_cell #(.BIT(OUT_W - d)) u_div (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .in_vld  (div_vld[d]),
                .in_bus  (div_bus[d]),
                .out_vld (div_vld[d+1]),
                .out_bus (div_bus[d+1])
            );
        end
    endgenerate

    always_comb begin
        if (tail.zero) begin
            res_next = '0;
        end else if (tail.neg) begin
            if (tail.ovf || tail.quo > OUT_W'(131072)) begin
                res_next = OUT_MIN;
            end else begin
                res_next = OUT_W'(~tail.quo + 1'b1);
            end
        end else begin
            if (tail.ovf || tail.quo > OUT_W'(131071)) begin
                res_next = OUT_MAX;
            end else begin
                res_next = tail.quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en && tail_vld) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail_vld) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_noise_value = res_reg;

endmodule

### tb/fractal_simplex_noise_2d_test.sv
module fractal_simplex_noise_2d_test;
    import fsn_pkg::*;

    localparam int LATENCY = 13 * MAX_OCTAVES_DEF + 21;
    localparam int CYCLE_LIMIT = 900000;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_coord_x = '0;
    logic signed [COORD_W-1:0] s_coord_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_noise_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;

    // Shadow copy of the register file, updated on each config beat.
    logic [CNT_W-1:0] sh_octaves = RST_OCTAVE_COUNT;
    logic [REG_W-1:0] sh_freq = RST_BASE_FREQUENCY;
    logic [REG_W-1:0] sh_amp = RST_BASE_AMPLITUDE;
    logic [REG_W-1:0] sh_lac = RST_LACUNARITY;
    logic [REG_W-1:0] sh_pers = RST_PERSISTENCE;

    logic signed [OUT_W-1:0] expected_noise[$];
    int errors = 0;
    int coords_sent = 0;
    int noise_checked = 0;
    int cfg_writes = 0;
    int cycles = 0;
    bit quiet_phase = 1'b0;

    fractal_simplex_noise_2d uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_noise_value(m_noise_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic longint grad_project(int unsigned h, longint x, longint y);
        int unsigned g;
        longint u, v, a, b;
        g = h & 32'h3F;
        u = (g < 4) ? x : y;
        v = (g < 4) ? y : x;
        a = g[0] ? -u : u;
        b = g[1] ? -2 * v : 2 * v;
        return a + b;
    endfunction

    function automatic longint corner_contrib(int unsigned h, longint x, longint y);
        longint t;
        t = FX_HALF - ((x * x) >>> 16) - ((y * y) >>> 16);
        if (t < 0) begin
            return 0;
        end
        t = (t * t) >>> 16;
        t = (t * t) >>> 16;
        return t * grad_project(h, x, y);
    endfunction

    function automatic int unsigned perm(longint idx);
        return PERM_ROM[int'(idx & 255)];
    endfunction

    function automatic longint simplex_octave(longint px, longint py);
        longint s, ci, cj, t, x0, y0, x1, y1, x2, y2, oi, oj, acc;
        int unsigned h0, h1, h2;
        s = ((px + py) * longint'(SKEW_F)) >>> 16;
        ci = (px + s) >>> 16;
        cj = (py + s) >>> 16;
        t = (ci + cj) * longint'(SKEW_G);
        x0 = px - ci * FX_ONE + t;
        y0 = py - cj * FX_ONE + t;
        oi = (x0 > y0) ? 1 : 0;
        oj = 1 - oi;
        x1 = x0 - oi * FX_ONE + longint'(SKEW_G);
        y1 = y0 - oj * FX_ONE + longint'(SKEW_G);
        x2 = x0 - FX_ONE + 2 * longint'(SKEW_G);
        y2 = y0 - FX_ONE + 2 * longint'(SKEW_G);
        h0 = perm(ci + perm(cj));
        h1 = perm(ci + oi + perm(cj + oj));
        h2 = perm(ci + 1 + perm(cj + 1));
        acc = corner_contrib(h0, x0, y0) + corner_contrib(h1, x1, y1)
            + corner_contrib(h2, x2, y2);
        return (acc * longint'(NOISE_GAIN)) >>> 32;
    endfunction

    function automatic longint grow_sat(longint a, longint m);
        longint r;
        r = (a * m) >>> 16;
        return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
    endfunction

    function automatic logic signed [OUT_W-1:0] fractal_noise(longint cx, longint cy);
        longint n, freq, amp, sum, total, r;
        n = (sh_octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : sh_octaves;
        freq = sh_freq;
        amp = sh_amp;
        sum = 0;
        total = 0;
        r = 0;
        for (longint k = 0; k < n; k++) begin
            sum += amp * simplex_octave((cx * freq) >>> 21, (cy * freq) >>> 21);
            total += amp;
            freq = grow_sat(freq, sh_lac);
            amp = grow_sat(amp, sh_pers);
        end
        if (total != 0) begin
            r = sum / total;
        end
        if (r > longint'(OUT_MAX)) begin
            r = OUT_MAX;
        end
        if (r < longint'(OUT_MIN)) begin
            r = OUT_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic int gap_len();
        int roll;
        if (quiet_phase) begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            cfg_writes <= cfg_writes + 1;
            case (cfg_index)
                REG_OCTAVE_COUNT: sh_octaves <= cfg_data[CNT_W-1:0];
                REG_BASE_FREQUENCY: sh_freq <= cfg_data;
                REG_BASE_AMPLITUDE: sh_amp <= cfg_data;
                REG_LACUNARITY: sh_lac <= cfg_data;
                REG_PERSISTENCE: sh_pers <= cfg_data;
                default: ;
            endcase
        end
        if (aresetn && s_valid && s_ready) begin
            expected_noise.push_back(fractal_noise(s_coord_x, s_coord_y));
        end
        if (aresetn && m_valid && m_ready) begin
            noise_checked <= noise_checked + 1;
            if (expected_noise.size() == 0) begin
                $error("noise_value: unexpected beat, actual %0d", m_noise_value);
                errors++;
            end else begin
                if (m_noise_value !== expected_noise[0]) begin
                    $error("noise_value: expected %0d, actual %0d",
                           expected_noise[0], m_noise_value);
                    errors++;
                end
                void'(expected_noise.pop_front());
            end
        end
    end

    // The result side stalls in bursts of the same shape as the sender's gaps.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            stall = gap_len();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Valid stays high across back-to-back beats and drops only for a gap;
    // callers lower it once they stop sending.
    task automatic send_coord(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_coord_x <= x;
        s_coord_y <= y;
        do @(posedge aclk); while (!s_ready);
        coords_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
        s_valid <= 1'b0;
        wait (expected_noise.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [REG_W-1:0] octaves, logic [REG_W-1:0] freq,
                              logic [REG_W-1:0] amp, logic [REG_W-1:0] lac,
                              logic [REG_W-1:0] pers);
        write_reg(REG_OCTAVE_COUNT, octaves);
        write_reg(REG_BASE_FREQUENCY, freq);
        write_reg(REG_BASE_AMPLITUDE, amp);
        write_reg(REG_LACUNARITY, lac);
        write_reg(REG_PERSISTENCE, pers);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        // Mostly a moderate range where the noise varies, sometimes any value.
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
    endfunction

    task automatic test_coordinate_extremes();
        quiet_phase = 1'b1;
        send_coord(0, 0);
        send_coord(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_coord(32'sh8000_0000, 32'sh8000_0000);
        send_coord(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_coord(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_coord(-1, -1);
        send_coord(32'sh0001_8000, -32'sh0002_4000);
        quiet_phase = 1'b0;
    endtask

    task automatic test_octave_limits();
        // Zero octaves give zero, counts above the limit are clamped, and the
        // upper data bits of the count register are dropped.
        set_config(0, 24'h010000, 24'h010000, 24'h020000, 24'h008000);
        send_coord(32'sh0012_3456, 32'sh0065_4321);
        write_reg(REG_OCTAVE_COUNT, 24'hFFFFF8);
        send_coord(32'sh0012_3456, 32'sh0065_4321);
        send_coord(-32'sh0033_0000, 32'sh0001_0000);
        write_reg(REG_OCTAVE_COUNT, 24'h00000F);
        send_coord(32'sh0012_3456, 32'sh0065_4321);
        write_reg(REG_OCTAVE_COUNT, 24'h00000C);
        send_coord(-32'sh0012_3456, 32'sh0065_4321);
    endtask

    task automatic test_zero_amplitude();
        set_config(4, 24'h020000, 24'h000000, 24'h020000, 24'h008000);
        send_coord(32'sh0040_0000, 32'sh0011_0000);
        set_config(3, 24'h020000, 24'h000001, 24'h020000, 24'h000000);
        send_coord(32'sh0040_0000, 32'sh0011_0000);
    endtask

    task automatic test_saturating_growth();
        set_config(8, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_coord(32'sh0000_1234, -32'sh0000_4321);
        send_coord(32'sh7FFF_FFFF, 32'sh8000_0000);
        set_config(8, 24'h000000, 24'h010000, 24'h000000, 24'h010000);
        send_coord(32'sh0123_4567, 32'sh0765_4321);
    endtask

    task automatic test_spare_registers();
        // Writes beyond the last register must leave the settings alone.
        set_config(2, 24'h018000, 24'h00C000, 24'h01C000, 24'h00A000);
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h000000);
        send_coord(32'sh0020_0000, -32'sh0018_0000);
        send_coord(-32'sh0007_0000, 32'sh0003_8000);
    endtask

    task automatic test_random_coords();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                set_config(REG_W'(RST_OCTAVE_COUNT), RST_BASE_FREQUENCY, RST_BASE_AMPLITUDE,
                           RST_LACUNARITY, RST_PERSISTENCE);
            end else begin
                set_config(REG_W'($urandom_range(15)), REG_W'($urandom_range(24'h080000)),
                           ($urandom_range(7) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(24'h020000)),
                           ($urandom_range(7) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(24'h030000)),
                           ($urandom_range(7) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(24'h010000)));
            end
            quiet_phase = (phase == 3);
            for (int i = 0; i < 250; i++) begin
                send_coord(rand_coord(), rand_coord());
            end
            quiet_phase = 1'b0;
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_coordinate_extremes();
        test_octave_limits();
        test_zero_amplitude();
        test_saturating_growth();
        test_spare_registers();
        test_random_coords();
        s_valid <= 1'b0;
        wait (expected_noise.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d coordinates and checked %0d noise values", coords_sent,
                 noise_checked);
        $display("across %0d register writes, including clamp and zero-weight cases.",
                 cfg_writes);
        if (errors == 0 && expected_noise.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
